// ===== hdl/ndem_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ndem_pkg: shared types and constants for the neighbour difference edge map
// Holds the pixel format, the per-channel difference pair, the limits of the
// frame geometry and the configuration register indexes.
// ----------------------------------------------------------------------------
package ndem_pkg;

	localparam int MAX_WIDTH  = 2048;
	localparam int MAX_HEIGHT = 2048;
	localparam int COL_W      = $clog2(MAX_WIDTH);
	localparam int ROW_W      = $clog2(MAX_HEIGHT);
	localparam int CFG_W      = 12;
	localparam int CHAN_W     = 8;
	localparam int NUM_CHAN   = 3;
	localparam int SUM_W      = CHAN_W + 2;
	localparam int IDX_W      = 2;

	localparam logic [CFG_W-1:0]  WIDTH_RESET  = CFG_W'(1920);
	localparam logic [CFG_W-1:0]  HEIGHT_RESET = CFG_W'(1080);
	localparam logic [CHAN_W-1:0] SAT_LIMIT    = CHAN_W'(255);

	localparam logic [IDX_W-1:0] REG_FRAME_WIDTH  = IDX_W'(0);
	localparam logic [IDX_W-1:0] REG_FRAME_HEIGHT = IDX_W'(1);

	typedef logic [CHAN_W-1:0] chan_t;

	typedef struct packed {
		chan_t red;
		chan_t green;
		chan_t blue;
	} pix_t;

	typedef struct packed {
		chan_t across;
		chan_t down;
	} diff_t;

	typedef struct packed {
		logic has_pend;
		logic last_row;
		logic last_col;
	} ctrl_t;

endpackage
`default_nettype wire

// ===== hdl/neighbour_difference_edge_map_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// neighbour_difference_edge_map_core: forward difference edge map, RGB stream
// Pipeline: a pixel beat is registered through stage one (line buffer read),
//   stage two (lane differences) and stage three, which drives result beats.
// Throughput: one pixel per cycle unless the result port stalls; last-row
//   pixels give two result beats each, so there the output port limits the rate.
// Reset: counters clear, geometry returns to 1920 x 1080, pipeline empties;
//   the line buffer is not cleared and holds data only once a row is written.
// ----------------------------------------------------------------------------
module neighbour_difference_edge_map_core (
	input  wire                        clk,
	input  wire                        arst_n,
	input  wire                        cfg_valid,
	output logic                       cfg_ready,
	input  wire [ndem_pkg::IDX_W-1:0]  cfg_index,
	input  wire [ndem_pkg::CFG_W-1:0]  cfg_data,
	input  wire                        pixel_valid,
	output logic                       pixel_ready,
	input  wire [7:0]                  pixel_blue,
	input  wire [7:0]                  pixel_green,
	input  wire [7:0]                  pixel_red,
	output logic                       result_valid,
	input  wire                        result_ready,
	output logic [7:0]                 edge_across,
	output logic [7:0]                 edge_down,
	output logic [7:0]                 edge_total,
	output logic                       end_of_frame,
	output logic                       last_of_run
);
	import ndem_pkg::*;

	logic [COL_W-1:0] col_last_q;
	logic [ROW_W-1:0] row_last_q;
	logic [COL_W-1:0] col_q;
	logic [ROW_W-1:0] row_q;

	logic  accept;
	logic  en1;
	logic  en2;
	logic  en3;
	ctrl_t ctrl_d;
	pix_t  cur_d;

	logic  s1_v;
	ctrl_t ctrl_s1;
	pix_t  cur_s1;
	pix_t  above_s1;
	pix_t  right_s1;

	logic  s2_v;
	ctrl_t ctrl_s2;
	diff_t diff_s2 [NUM_CHAN];

	chan_t across_m;
	chan_t down_m;
	chan_t total_m;

	logic  s3_v;
	logic  pend_s3;
	logic  zero_s3;
	logic  eof_s3;
	chan_t across_s3;
	chan_t down_s3;
	chan_t total_s3;
	logic  final_beat;

	// configuration
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_last_q <= COL_W'(WIDTH_RESET - 1'b1);
			row_last_q <= ROW_W'(HEIGHT_RESET - 1'b1);
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_FRAME_WIDTH: begin
					if (cfg_data < CFG_W'(2)) begin
						col_last_q <= COL_W'(1);
					end else if (32'(cfg_data) > MAX_WIDTH) begin
						col_last_q <= COL_W'(MAX_WIDTH - 1);
					end else begin
						col_last_q <= COL_W'(cfg_data - 1'b1);
					end
				end
				REG_FRAME_HEIGHT: begin
					if (cfg_data < CFG_W'(2)) begin
						row_last_q <= ROW_W'(1);
					end else if (32'(cfg_data) > MAX_HEIGHT) begin
						row_last_q <= ROW_W'(MAX_HEIGHT - 1);
					end else begin
						row_last_q <= ROW_W'(cfg_data - 1'b1);
					end
				end
				default: begin
				end
			endcase
		end
	end

	// stage enables
	assign final_beat  = !(pend_s3 && zero_s3);
	assign en3         = !s3_v || (result_ready && final_beat);
	assign en2         = !s2_v || en3;
	assign en1         = !s1_v || en2;
	assign pixel_ready = en1;
	assign accept      = pixel_valid && pixel_ready;

	assign cur_d.blue  = pixel_blue;
	assign cur_d.green = pixel_green;
	assign cur_d.red   = pixel_red;

	assign ctrl_d.has_pend = (row_q != '0);
	assign ctrl_d.last_row = (row_q >= row_last_q);
	assign ctrl_d.last_col = (col_q >= col_last_q);

	// raster position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (ctrl_d.last_col) begin
				col_q <= '0;
				row_q <= ctrl_d.last_row ? '0 : ROW_W'(row_q + 1'b1);
			end else begin
				col_q <= COL_W'(col_q + 1'b1);
			end
		end
	end

	ndem_line_buf u_line_buf (
		.clk          (clk),
		.wr_en        (accept),
		.wr_addr      (col_q),
		.wr_data      (cur_d),
		.rd_en        (accept),
		.rd_addr_a    (col_q),
		.rd_addr_b    (COL_W'(col_q + 1'b1)),
		.rd_data_a_s1 (above_s1),
		.rd_data_b_s1 (right_s1)
	);

	// stage one
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_v <= 1'b0;
		end else if (en1) begin
			s1_v <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			ctrl_s1 <= ctrl_d;
			cur_s1  <= cur_d;
		end
	end

	// stage two: one lane per channel
	ndem_lane u_lane_blue (
		.clk     (clk),
		.en      (en2),
		.above   (above_s1.blue),
		.right   (right_s1.blue),
		.below   (cur_s1.blue),
		.diff_s2 (diff_s2[0])
	);

	ndem_lane u_lane_green (
		.clk     (clk),
		.en      (en2),
		.above   (above_s1.green),
		.right   (right_s1.green),
		.below   (cur_s1.green),
		.diff_s2 (diff_s2[1])
	);

	ndem_lane u_lane_red (
		.clk     (clk),
		.en      (en2),
		.above   (above_s1.red),
		.right   (right_s1.red),
		.below   (cur_s1.red),
		.diff_s2 (diff_s2[2])
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s2_v <= 1'b0;
		end else if (en2) begin
			s2_v <= s1_v;
		end
	end

	always_ff @(posedge clk) begin
		if (en2) begin
			ctrl_s2 <= ctrl_s1;
		end
	end

	ndem_merge u_merge (
		.diff     (diff_s2),
		.last_col (ctrl_s2.last_col),
		.across   (across_m),
		.down     (down_m),
		.total    (total_m)
	);

	// stage three: output register, up to two beats per pixel
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s3_v    <= 1'b0;
			pend_s3 <= 1'b0;
			zero_s3 <= 1'b0;
		end else if (en3) begin
			s3_v    <= s2_v && (ctrl_s2.has_pend || ctrl_s2.last_row);
			pend_s3 <= s2_v && ctrl_s2.has_pend;
			zero_s3 <= s2_v && ctrl_s2.last_row;
		end else if (result_ready) begin
			pend_s3 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (en3) begin
			across_s3 <= across_m;
			down_s3   <= down_m;
			total_s3  <= total_m;
			eof_s3    <= ctrl_s2.last_col;
		end
	end

	assign result_valid = s3_v;
	assign edge_across  = pend_s3 ? across_s3 : '0;
	assign edge_down    = pend_s3 ? down_s3 : '0;
	assign edge_total   = pend_s3 ? total_s3 : '0;
	assign end_of_frame = !pend_s3 && eof_s3;
	assign last_of_run  = final_beat;

endmodule
`default_nettype wire

// ===== hdl/ndem_line_buf.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ndem_line_buf: one-row line buffer
// Single write port and two read ports; read data is registered and reflects
// the contents before a write to the same address in the same cycle.
// ----------------------------------------------------------------------------
module ndem_line_buf (
	input  wire                      clk,
	input  wire                      wr_en,
	input  wire [ndem_pkg::COL_W-1:0] wr_addr,
	input  wire ndem_pkg::pix_t      wr_data,
	input  wire                      rd_en,
	input  wire [ndem_pkg::COL_W-1:0] rd_addr_a,
	input  wire [ndem_pkg::COL_W-1:0] rd_addr_b,
	output ndem_pkg::pix_t           rd_data_a_s1,
	output ndem_pkg::pix_t           rd_data_b_s1
);
	import ndem_pkg::*;

	pix_t mem_q [MAX_WIDTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_a_s1 <= mem_q[rd_addr_a];
			rd_data_b_s1 <= mem_q[rd_addr_b];
		end
	end

endmodule
`default_nettype wire

// ===== hdl/ndem_lane.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ndem_lane: per-channel difference lane
// Forms the absolute difference of one color channel to the right neighbour
// and to the pixel below, registered into stage two.
// ----------------------------------------------------------------------------
module ndem_lane (
	input  wire                  clk,
	input  wire                  en,
	input  wire ndem_pkg::chan_t above,
	input  wire ndem_pkg::chan_t right,
	input  wire ndem_pkg::chan_t below,
	output ndem_pkg::diff_t      diff_s2
);
	import ndem_pkg::*;

	chan_t across_d;
	chan_t down_d;

	assign across_d = (above > right) ? chan_t'(above - right) : chan_t'(right - above);
	assign down_d   = (above > below) ? chan_t'(above - below) : chan_t'(below - above);

	always_ff @(posedge clk) begin
		if (en) begin
			diff_s2.across <= across_d;
			diff_s2.down   <= down_d;
		end
	end

endmodule
`default_nettype wire

// ===== hdl/ndem_merge.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ndem_merge: lane merge
// Sums the channel differences of all lanes, saturates each edge and their
// total, and forces zeros for the last column.
// ----------------------------------------------------------------------------
module ndem_merge (
	input  wire ndem_pkg::diff_t   diff [ndem_pkg::NUM_CHAN],
	input  wire                    last_col,
	output ndem_pkg::chan_t        across,
	output ndem_pkg::chan_t        down,
	output ndem_pkg::chan_t        total
);
	import ndem_pkg::*;

	logic [SUM_W-1:0] across_sum;
	logic [SUM_W-1:0] down_sum;
	logic [SUM_W-1:0] total_sum;
	chan_t            across_sat;
	chan_t            down_sat;
	chan_t            total_sat;

	always_comb begin
		across_sum = '0;
		down_sum   = '0;
		for (int k = 0; k < NUM_CHAN; k++) begin
			across_sum = across_sum + SUM_W'(diff[k].across);
			down_sum   = down_sum + SUM_W'(diff[k].down);
		end
		across_sat = (across_sum > SUM_W'(SAT_LIMIT)) ? SAT_LIMIT : across_sum[CHAN_W-1:0];
		down_sat   = (down_sum > SUM_W'(SAT_LIMIT)) ? SAT_LIMIT : down_sum[CHAN_W-1:0];
		total_sum  = SUM_W'(across_sat) + SUM_W'(down_sat);
		total_sat  = (total_sum > SUM_W'(SAT_LIMIT)) ? SAT_LIMIT : total_sum[CHAN_W-1:0];
	end

	assign across = last_col ? '0 : across_sat;
	assign down   = last_col ? '0 : down_sat;
	assign total  = last_col ? '0 : total_sat;

endmodule
`default_nettype wire

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for neighbour_difference_edge_map_core
// Streams RGB pixels into the edge map under random backpressure. Every result
// beat is compared with an in-bench model of the line buffer, the saturated
// channel differences and the row and column counters. The frame geometry is
// changed between bursts, including mid-frame, and is driven to both limits.
// ----------------------------------------------------------------------------
module tb_top;
	import ndem_pkg::*;

	localparam logic [IDX_W-1:0] REG_SPARE_A = IDX_W'(2);
	localparam logic [IDX_W-1:0] REG_SPARE_B = IDX_W'(3);
	localparam int SETTLE_CYCLES = 8;
	localparam int RANDOM_PIXELS = 450;
	localparam int LIMIT_PIXELS  = 64;
	localparam int REPORT_CAP    = 100;

	localparam pix_t CORNER_PIXELS [12] = '{
		24'h000000, 24'hFFFFFF, 24'h000000, 24'hFF00FF,
		24'hFFFFFF, 24'h000000, 24'h808080, 24'h010203,
		24'h00FF00, 24'h7F7F7F, 24'hFFFFFF, 24'h000000
	};

	typedef struct packed {
		chan_t across;
		chan_t down;
		chan_t total;
		logic  eof;
		logic  last;
	} edge_beat_t;

	typedef enum logic [1:0] {RX_OPEN, RX_RANDOM, RX_PERIODIC, RX_CHOKED} rx_mode_t;

	class edge_map_tracker;
		logic [CFG_W-1:0] width_reg;
		logic [CFG_W-1:0] height_reg;
		pix_t             line_buf [MAX_WIDTH];
		bit               filled [MAX_WIDTH];
		int unsigned      col;
		int unsigned      row;
		edge_beat_t       expected_edges [$];
		int unsigned      errors;
		int unsigned      pixels;
		int unsigned      beats;
		int unsigned      frames;
		int unsigned      widest;
		int unsigned      tallest;

		function new();
			width_reg  = WIDTH_RESET;
			height_reg = HEIGHT_RESET;
			col = 0;
			row = 0;
			errors = 0;
			pixels = 0;
			beats = 0;
			frames = 0;
			widest = 0;
			tallest = 0;
			foreach (filled[i]) filled[i] = 1'b0;
		endfunction

		function int unsigned clamp_dim(logic [CFG_W-1:0] v, int unsigned hi);
			if (v < 2) return 2;
			if (v > hi) return hi;
			return v;
		endfunction

		function chan_t distance(pix_t a, pix_t b);
			int s;
			int d;
			s = 0;
			for (int k = 0; k < NUM_CHAN; k++) begin
				d = int'(a[CHAN_W*k +: CHAN_W]) - int'(b[CHAN_W*k +: CHAN_W]);
				s += (d < 0) ? -d : d;
			end
			return (s > int'(SAT_LIMIT)) ? SAT_LIMIT : chan_t'(s);
		endfunction

		// a wider row may only read line buffer entries that hold data
		function bit width_write_safe(logic [CFG_W-1:0] v);
			int unsigned w;
			w = clamp_dim(v, MAX_WIDTH);
			if (row == 0) return 1'b1;
			for (int i = 0; i < w; i++)
				if (!filled[i]) return 1'b0;
			return 1'b1;
		endfunction

		function void set_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] v);
			case (idx)
				REG_FRAME_WIDTH:  width_reg = v;
				REG_FRAME_HEIGHT: height_reg = v;
				default: ;
			endcase
		endfunction

		function void queue_beat(edge_beat_t b);
			expected_edges = {expected_edges, b};
		endfunction

		function void note_pixel(pix_t p);
			int unsigned w;
			int unsigned h;
			int          sum;
			bit          last_col;
			bit          last_row;
			edge_beat_t  b;
			w = clamp_dim(width_reg, MAX_WIDTH);
			h = clamp_dim(height_reg, MAX_HEIGHT);
			last_col = (col >= w - 1);
			last_row = (row >= h - 1);
			if (row != 0) begin
				b = '0;
				if (!last_col) begin
					b.across = distance(line_buf[col], line_buf[col + 1]);
					b.down   = distance(line_buf[col], p);
					sum = int'(b.across) + int'(b.down);
					b.total  = (sum > int'(SAT_LIMIT)) ? SAT_LIMIT : chan_t'(sum);
				end
				b.last = !last_row;
				queue_beat(b);
			end
			if (last_row) begin
				b = '0;
				b.eof  = last_col;
				b.last = 1'b1;
				queue_beat(b);
			end
			line_buf[col] = p;
			filled[col] = 1'b1;
			pixels++;
			if (w > widest) widest = w;
			if (h > tallest) tallest = h;
			if (last_col) begin
				col = 0;
				row = last_row ? 0 : row + 1;
			end else begin
				col++;
			end
		endfunction

		function void compare(string field, int unsigned want, int unsigned got);
			if (want != got) begin
				errors++;
				if (errors <= REPORT_CAP)
					$display("%0t: %s mismatch, expected %0d, actual %0d",
						$time, field, want, got);
			end
		endfunction

		function void check_edge(edge_beat_t got);
			edge_beat_t want;
			beats++;
			if (expected_edges.size() == 0) begin
				errors++;
				if (errors <= REPORT_CAP)
					$display(
						"%0t: unexpected result beat, expected none, actual %0d/%0d/%0d/%0b/%0b",
						$time, got.across, got.down, got.total, got.eof, got.last);
				return;
			end
			want = expected_edges.pop_front();
			if (want.eof) frames++;
			compare("edge_across", want.across, got.across);
			compare("edge_down", want.down, got.down);
			compare("edge_total", want.total, got.total);
			compare("end_of_frame", want.eof, got.eof);
			compare("last_of_run", want.last, got.last);
		endfunction
	endclass

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                cfg_valid = 1'b0;
	logic [IDX_W-1:0]    cfg_index = REG_FRAME_WIDTH;
	logic [CFG_W-1:0]    cfg_data = '0;
	logic                pixel_valid = 1'b0;
	logic [7:0]          pixel_blue = '0;
	logic [7:0]          pixel_green = '0;
	logic [7:0]          pixel_red = '0;
	logic                result_ready = 1'b0;
	wire                 cfg_ready;
	wire                 pixel_ready;
	wire                 result_valid;
	wire [7:0]           edge_across;
	wire [7:0]           edge_down;
	wire [7:0]           edge_total;
	wire                 end_of_frame;
	wire                 last_of_run;

	edge_map_tracker     edge_tracker = new();
	rx_mode_t            rx_mode = RX_OPEN;
	int unsigned         rx_mode_left = 100;
	int unsigned         rx_tick = 0;
	int unsigned         burst_left = 0;
	int                  smooth_level = 128;

	neighbour_difference_edge_map_core DUT (.*);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n && result_valid && result_ready)
			edge_tracker.check_edge({edge_across, edge_down, edge_total, end_of_frame,
				last_of_run});
		if (rx_mode_left == 0) begin
			rx_mode <= rx_mode_t'($urandom_range(0, 3));
			rx_mode_left <= $urandom_range(20, 300);
		end else
			rx_mode_left <= rx_mode_left - 1;
		case (rx_mode)
			RX_OPEN:     result_ready <= 1'b1;
			RX_RANDOM:   result_ready <= ($urandom_range(0, 3) != 0);
			RX_PERIODIC: result_ready <= (rx_tick % 3 != 0);
			RX_CHOKED:   result_ready <= ($urandom_range(0, 9) == 0);
		endcase
		rx_tick <= rx_tick + 1;
	end

	function automatic pix_t draw_pixel();
		pix_t p;
		int   v;
		case ($urandom_range(0, 3))
			0: p = pix_t'(24'($urandom));
			1: begin
				for (int k = 0; k < NUM_CHAN; k++)
					p[CHAN_W*k +: CHAN_W] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
			end
			default: begin
				smooth_level += int'($urandom_range(0, 12)) - 6;
				if (smooth_level < 0) smooth_level = 0;
				if (smooth_level > 255) smooth_level = 255;
				for (int k = 0; k < NUM_CHAN; k++) begin
					v = smooth_level + int'($urandom_range(0, 24)) - 12;
					p[CHAN_W*k +: CHAN_W] = chan_t'((v < 0) ? 0 : (v > 255) ? 255 : v);
				end
			end
		endcase
		return p;
	endfunction

	function automatic logic [CFG_W-1:0] draw_width();
		case ($urandom_range(0, 9))
			0:       return CFG_W'($urandom_range(0, 1));
			1:       return CFG_W'($urandom_range(13, 64));
			default: return CFG_W'($urandom_range(2, 12));
		endcase
	endfunction

	function automatic logic [CFG_W-1:0] draw_height();
		case ($urandom_range(0, 9))
			0:       return CFG_W'($urandom_range(0, 1));
			1:       return CFG_W'($urandom_range(7, 20));
			default: return CFG_W'($urandom_range(2, 6));
		endcase
	endfunction

	task automatic push_pixel(pix_t p);
		pixel_valid <= 1'b1;
		pixel_blue  <= p.blue;
		pixel_green <= p.green;
		pixel_red   <= p.red;
		do @(posedge clk); while (!pixel_ready);
		edge_tracker.note_pixel(p);
	endtask

	task automatic pause_pixels(int unsigned n);
		if (n == 0) return;
		pixel_valid <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	task automatic stream_pixel(pix_t p);
		if (burst_left == 0) begin
			pause_pixels(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8));
			burst_left = $urandom_range(1, 40);
		end
		burst_left--;
		push_pixel(p);
	endtask

	// hold off until every expected beat is back and the pipeline is empty
	task automatic drain();
		pixel_valid <= 1'b0;
		do @(posedge clk); while (edge_tracker.expected_edges.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
		burst_left = 0;
	endtask

	task automatic write_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] v);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= v;
		do @(posedge clk); while (!cfg_ready);
		edge_tracker.set_reg(idx, v);
	endtask

	task automatic reconfigure(bit set_w, logic [CFG_W-1:0] w, bit set_h,
			logic [CFG_W-1:0] h);
		drain();
		if (set_w) write_reg(REG_FRAME_WIDTH, w);
		if (set_h) write_reg(REG_FRAME_HEIGHT, h);
		cfg_valid <= 1'b0;
	endtask

	task automatic finish_frame();
		while (edge_tracker.col != 0 || edge_tracker.row != 0)
			stream_pixel(draw_pixel());
	endtask

	initial begin
		int unsigned      random_pixels;
		logic [CFG_W-1:0] next_width;
		random_pixels = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// saturating and all-equal neighbours in a 4 x 3 frame
		reconfigure(1'b1, CFG_W'(4), 1'b1, CFG_W'(3));
		foreach (CORNER_PIXELS[i]) stream_pixel(CORNER_PIXELS[i]);

		// clamp both dimensions up to two, ignore spare indexes
		drain();
		write_reg(REG_SPARE_A, '1);
		write_reg(REG_FRAME_WIDTH, CFG_W'(0));
		write_reg(REG_FRAME_HEIGHT, CFG_W'(1));
		write_reg(REG_SPARE_B, '0);
		cfg_valid <= 1'b0;
		repeat (4) stream_pixel(draw_pixel());

		// shrink the row while the column counter sits past the new end
		reconfigure(1'b1, CFG_W'(6), 1'b1, CFG_W'(4));
		repeat (9) stream_pixel(draw_pixel());
		reconfigure(1'b1, CFG_W'(3), 1'b0, '0);
		repeat (2) stream_pixel(draw_pixel());

		while (random_pixels < RANDOM_PIXELS) begin
			if ($urandom_range(0, 2) == 0) begin
				next_width = draw_width();
				reconfigure(edge_tracker.width_write_safe(next_width) &&
					$urandom_range(0, 3) != 0, next_width,
					$urandom_range(0, 3) != 0, draw_height());
			end
			repeat ($urandom_range(5, 80)) begin
				stream_pixel(draw_pixel());
				random_pixels++;
				if ($urandom_range(0, 199) == 0) drain();
			end
		end

		// cut the frame short, then widest row and tallest frame from clamped values
		reconfigure(1'b0, '0, 1'b1, CFG_W'(2));
		finish_frame();
		reconfigure(1'b1, '1, 1'b1, CFG_W'(0));
		repeat (LIMIT_PIXELS) stream_pixel(draw_pixel());
		reconfigure(1'b1, CFG_W'(1), 1'b1, '1);
		repeat (LIMIT_PIXELS) stream_pixel(draw_pixel());

		drain();
		$display("Streamed %0d pixels, checked %0d result beats over %0d complete frames.",
			edge_tracker.pixels, edge_tracker.beats, edge_tracker.frames);
		$display("Geometry ran from 2 x 2 up to rows of %0d and frames of %0d; %0d mismatches.",
			edge_tracker.widest, edge_tracker.tallest, edge_tracker.errors);
		if (edge_tracker.errors == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

	initial begin
		#20_000_000;
		$display("Timeout with %0d result beats outstanding",
			edge_tracker.expected_edges.size());
		$display("Regression FAIL");
		$finish;
	end

endmodule
